// File: rtl/sorted_pair_sum_search_assert.svh
// Assertion macros for the sorted pair sum search block.
// Expects i_clk and i_rst_n in the scope of use; no other dependencies.
`ifndef SORTED_PAIR_SUM_SEARCH_ASSERT_SVH
`define SORTED_PAIR_SUM_SEARCH_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SPS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SPS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ssps_pkg.sv
// Shared types for the sorted pair sum search block.
// No dependencies.
`timescale 1ns / 1ps

package ssps_pkg;

    localparam int ELEM_W = 32;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [ELEM_W:0]   t_sum;

endpackage

// File: rtl/ssps_if.sv
// Valid/ready channels of the sorted pair sum search block.
// Depends on ssps_pkg.
`timescale 1ns / 1ps

interface ssps_elem_if;
    import ssps_pkg::*;
    logic  valid;
    logic  ready;
    t_elem element_value;
    logic  last_element;
    modport source (output valid, output element_value, output last_element, input ready);
    modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface ssps_res_if;
    logic valid;
    logic ready;
    logic pair_found;
    modport source (output valid, output pair_found, input ready);
    modport sink   (input valid, input pair_found, output ready);
endinterface

interface ssps_cfg_if;
    import ssps_pkg::*;
    logic  valid;
    logic  ready;
    t_elem target_sum;
    modport source (output valid, output target_sum, input ready);
    modport sink   (input valid, input target_sum, output ready);
endinterface

// File: rtl/sorted_pair_sum_search.sv
// Sorted pair sum search. Elements arrive one word per cycle on i_elem while the
// block is idle and are written into a single RAM of MAX_ELEMS entries; words
// beyond MAX_ELEMS in a set are dropped, though a dropped last word still starts
// the search. On the last word the stored set of n elements is bubble sorted in
// place in n-1 passes, then a two-pointer search runs from both ends. Both phases
// are bound by the single read port of the RAM; a read of the entry written in
// the same cycle is served from a one-word forwarding register. One word reports
// pair_found; a set of fewer than two elements reports 0 straight away. Input is
// held off from the last word until the result is handed to the output register,
// which may still wait for o_res.ready while the next set loads. target_sum is
// written over i_cfg and resets to 0; the user must write it only while the
// block is idle, as the block itself does not enforce it.
// Depends on ssps_pkg, ssps_if, ssps_ram and sorted_pair_sum_search_assert.svh.
`timescale 1ns / 1ps

module sorted_pair_sum_search #(
    parameter int MAX_ELEMS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssps_elem_if.sink   i_elem,
    ssps_cfg_if.sink    i_cfg,
    ssps_res_if.source  o_res
);
    import ssps_pkg::*;

    `include "sorted_pair_sum_search_assert.svh"

    localparam int ADDR_W = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ELEMS + 1);

    typedef enum logic [2:0] {
        S_IDLE,     // loading words
        S_LOAD,     // first element of a sort pass arrives as carry
        S_CMP,      // compare carry with next lower entry, write back the larger
        S_WB,       // write pass minimum to its final place
        S_SR_LO0,   // search start: low value arrives, fetch high
        S_SR_FETCH, // one pointer value arrives
        S_SR_CMP,   // add, compare, step a pointer
        S_DONE      // hand result to output register
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_n;
    logic [ADDR_W-1:0]   r_pass;
    logic [ADDR_W-1:0]   r_pos;
    logic [ADDR_W-1:0]   r_lo;
    logic [ADDR_W-1:0]   r_hi;
    logic                r_fetch_hi;
    t_elem               r_carry;
    t_elem               r_vlo;
    t_elem               r_vhi;
    t_elem               r_target;
    logic                r_found;
    logic                r_out_valid;
    logic                r_out_found;
    logic                r_fwd_hit;
    t_elem               r_fwd_data;

    // RAM port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ELEM_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ELEM_W-1:0]   ram_rdata;
    t_elem               w_rd;

    logic                w_in_acc;
    logic                w_full;
    logic [CNT_W-1:0]    w_n_new;
    logic [ADDR_W-1:0]   w_pos_m1;
    logic                w_carry_lt;
    logic                w_more_pass;
    t_sum                w_sum;
    t_sum                w_tgt;
    logic                w_out_free;

    ssps_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ELEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // RAM is read-first: a same-entry write and read takes the written word
    assign w_rd        = r_fwd_hit ? r_fwd_data : t_elem'(ram_rdata);
    assign w_in_acc    = i_elem.valid && i_elem.ready;
    assign w_full      = (r_count == CNT_W'(MAX_ELEMS));
    assign w_n_new     = w_full ? r_count : (r_count + CNT_W'(1));
    assign w_pos_m1    = r_pos - ADDR_W'(1);
    assign w_carry_lt  = (r_carry < w_rd);
    assign w_more_pass = ((CNT_W'(r_pass) + CNT_W'(2)) < r_n);
    assign w_sum       = t_sum'(r_vlo) + t_sum'(r_vhi);
    assign w_tgt       = t_sum'(r_target);
    assign w_out_free  = !r_out_valid || o_res.ready;

    assign i_elem.ready    = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_res.valid     = r_out_valid;
    assign o_res.pair_found = r_out_found;

    // RAM control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_carry;
        ram_raddr = r_pos;
        unique case (r_state)
            S_IDLE: begin
                ram_we    = w_in_acc && !w_full;
                ram_waddr = r_count[ADDR_W-1:0];
                ram_wdata = i_elem.element_value;
                // top entry of the set seeds the first sort pass
                ram_raddr = ADDR_W'(w_n_new - CNT_W'(1));
            end
            S_LOAD: begin
                ram_raddr = ADDR_W'(r_n - CNT_W'(2));
            end
            S_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = w_carry_lt ? w_rd : r_carry;
                ram_raddr = w_pos_m1 - ADDR_W'(1);
            end
            S_WB: begin
                ram_we    = 1'b1;
                ram_waddr = r_pass;
                ram_wdata = r_carry;
                ram_raddr = w_more_pass ? ADDR_W'(r_n - CNT_W'(1)) : '0;
            end
            S_SR_LO0: begin
                ram_raddr = r_hi;
            end
            S_SR_CMP: begin
                ram_raddr = (w_sum > w_tgt) ? (r_hi - ADDR_W'(1)) : (r_lo + ADDR_W'(1));
            end
            S_SR_FETCH, S_DONE: begin
                ram_raddr = r_lo;
            end
            default: begin
                ram_raddr = r_lo;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_target    <= '0;
            r_fwd_hit   <= 1'b0;
        end else begin
            r_fwd_hit  <= ram_we && (ram_waddr == ram_raddr);
            r_fwd_data <= t_elem'(ram_wdata);
            if (i_cfg.valid) begin
                r_target <= i_cfg.target_sum;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_count <= i_elem.last_element ? '0 : w_n_new;
                        if (i_elem.last_element) begin
                            r_n     <= w_n_new;
                            r_pass  <= '0;
                            if (w_n_new < CNT_W'(2)) begin
                                r_found <= 1'b0;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_LOAD;
                            end
                        end
                    end
                end
                S_LOAD: begin
                    r_carry <= w_rd;
                    r_pos   <= ADDR_W'(r_n - CNT_W'(1));
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // larger value stays at r_pos, smaller travels down
                    if (!w_carry_lt) begin
                        r_carry <= w_rd;
                    end
                    r_pos <= w_pos_m1;
                    if (w_pos_m1 <= r_pass) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (w_more_pass) begin
                        r_pass  <= r_pass + ADDR_W'(1);
                        r_state <= S_LOAD;
                    end else begin
                        r_lo    <= '0;
                        r_hi    <= ADDR_W'(r_n - CNT_W'(1));
                        r_state <= S_SR_LO0;
                    end
                end
                S_SR_LO0: begin
                    r_vlo      <= w_rd;
                    r_fetch_hi <= 1'b1;
                    r_state    <= S_SR_FETCH;
                end
                S_SR_FETCH: begin
                    if (r_fetch_hi) begin
                        r_vhi <= w_rd;
                    end else begin
                        r_vlo <= w_rd;
                    end
                    r_state <= S_SR_CMP;
                end
                S_SR_CMP: begin
                    if (!(r_lo < r_hi)) begin
                        r_found <= 1'b0;
                        r_state <= S_DONE;
                    end else if (w_sum == w_tgt) begin
                        r_found <= 1'b1;
                        r_state <= S_DONE;
                    end else if (w_sum > w_tgt) begin
                        r_hi       <= r_hi - ADDR_W'(1);
                        r_fetch_hi <= 1'b1;
                        r_state    <= S_SR_FETCH;
                    end else begin
                        r_lo       <= r_lo + ADDR_W'(1);
                        r_fetch_hi <= 1'b0;
                        r_state    <= S_SR_FETCH;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_found <= r_found;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SPS_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_ELEMS), "element count over capacity")
    `SPS_ASSERT_NXT(a_set_restart, w_in_acc && i_elem.last_element, r_count == '0, "count not cleared after last word")
    `SPS_ASSERT_IMP(a_cmp_order, r_state == S_CMP, r_pos > r_pass, "sort position not above pass")
    `SPS_ASSERT_IMP(a_out_from_done, $rose(r_out_valid), $past(r_state == S_DONE), "result raised outside done")
    `SPS_ASSERT_IMP(a_ptr_range, r_state == S_SR_CMP, (CNT_W'(r_hi) < r_n) && (r_lo <= r_hi), "search pointers out of range")

endmodule

// File: rtl/ssps_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ssps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/pair_sum_checker.sv
// Checker for the sorted pair sum search block: watches the element, target and
// result channels, predicts pair_found per set and compares. Depends on ssps_pkg, ssps_if.
`timescale 1ns / 1ps

module pair_sum_checker #(
    parameter int MAX_ELEMS = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ssps_elem_if  elem_mon,
    ssps_cfg_if   cfg_mon,
    ssps_res_if   res_mon,
    output int    o_err_count,
    output int    o_pending
);
    import ssps_pkg::*;

    t_elem set_store [MAX_ELEMS];
    int    set_count = 0;
    t_elem target_sum = '0;
    logic  found_q [$];
    int    err_count = 0;

    task automatic report_mismatch(input string what);
        $display("pair_sum_checker: %0t ns: %s", $time, what);
        err_count++;
    endtask

    // sort a copy of the set, then walk inward from both ends
    function automatic logic predict_pair_found();
        t_elem ordered [MAX_ELEMS];
        t_elem swap;
        t_sum  pair_sum;
        int    lo;
        int    hi;
        for (int i = 0; i < set_count; i++) ordered[i] = set_store[i];
        for (int p = 0; p < set_count; p++) begin
            for (int q = set_count - 1; q > p; q--) begin
                if (ordered[q] < ordered[q-1]) begin
                    swap         = ordered[q];
                    ordered[q]   = ordered[q-1];
                    ordered[q-1] = swap;
                end
            end
        end
        lo = 0;
        hi = set_count - 1;
        while (lo < hi) begin
            pair_sum = t_sum'(ordered[lo]) + t_sum'(ordered[hi]);
            if (pair_sum > t_sum'(target_sum)) hi--;
            else if (pair_sum < t_sum'(target_sum)) lo++;
            else return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        logic exp_found;
        if (!i_rst_n) begin
            set_count  = 0;
            target_sum = '0;
            found_q.delete();
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) target_sum = cfg_mon.target_sum;
            if (elem_mon.valid && elem_mon.ready) begin
                // words past a full store are dropped, a dropped last word still ends the set
                if (set_count < MAX_ELEMS) begin
                    set_store[set_count] = elem_mon.element_value;
                    set_count++;
                end
                if (elem_mon.last_element) begin
                    found_q.push_back(predict_pair_found());
                    set_count = 0;
                end
            end
            if (res_mon.valid && res_mon.ready) begin
                if (found_q.size() == 0) begin
                    report_mismatch("result word with no set outstanding");
                end else begin
                    exp_found = found_q.pop_front();
                    if (res_mon.pair_found !== exp_found)
                        report_mismatch($sformatf("pair_found %b, expected %b",
                                                  res_mon.pair_found, exp_found));
                end
            end
        end
        o_err_count <= err_count;
        o_pending   <= found_q.size();
    end

endmodule

// File: tb/tb_top.sv
// Top of the sorted pair sum search testbench: clock, reset, stimulus and verdict.
// Depends on ssps_pkg, ssps_if, sorted_pair_sum_search and pair_sum_checker.
`timescale 1ns / 1ps

module tb_top;
    import ssps_pkg::*;

    localparam int     MAX_ELEMS  = 64;
    localparam int     N_ITEMS    = 650;
    localparam int     CYCLE_CAP  = 1000000;
    localparam int     PHASE_GAP  = 8;    // idle cycles before a target write
    localparam int     END_SETTLE = 32;
    localparam t_elem  ELEM_MIN   = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam t_elem  ELEM_MAX   = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam longint LIM_LO     = -64'sd2147483648;
    localparam longint LIM_HI     = 64'sd2147483647;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // period 2 ns
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    ssps_elem_if elem_ch ();
    ssps_cfg_if  cfg_ch ();
    ssps_res_if  res_ch ();

    sorted_pair_sum_search #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (elem_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    int chk_errors;
    int chk_pending;

    pair_sum_checker #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .elem_mon    (elem_ch),
        .cfg_mon     (cfg_ch),
        .res_mon     (res_ch),
        .o_err_count (chk_errors),
        .o_pending   (chk_pending)
    );

    bit idle_on    = 1'b1;  // cleared for phases that run flat out on both sides
    int items_sent = 0;
    int cycle_count = 0;

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure: ready drops for random stretches, so stalls land
    // on loading, sorting, searching and on a result that is already waiting.
    initial begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left   = pick_gap();
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // One element word; returns at the edge where it is taken. Valid is only
    // lowered when a gap follows, so back-to-back words keep it high.
    task automatic send_word(input t_elem value, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            elem_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        elem_ch.valid         <= 1'b1;
        elem_ch.element_value <= value;
        elem_ch.last_element  <= last;
        @(posedge i_clk);
        while (!elem_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_set(input t_elem vals [$]);
        foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
    endtask

    // Wait until every set has reported, then let the block settle.
    // Called at the edge of the last handshake.
    task automatic drain(input int settle);
        elem_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Only ever called with the block idle.
    task automatic write_target(input t_elem value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.target_sum <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Element content by set style:
    //   0-3 planted pair, 9 near miss: mixed small and wide fillers
    //   4-5 small values, 6-7 full width, 8 extremes only
    function automatic t_elem draw_value(input int style);
        t_elem corner [7];
        corner = '{ELEM_MIN, ELEM_MIN + 1, -1, 0, 1, ELEM_MAX - 1, ELEM_MAX};
        case (style)
            4, 5:    return $signed($urandom_range(0, 12)) - 6;
            6, 7:    return $urandom();
            8:       return corner[$urandom_range(0, 6)];
            default: return ($urandom_range(0, 2) == 0) ? t_elem'($urandom())
                                                         : $signed($urandom_range(0, 100)) - 50;
        endcase
    endfunction

    // Mostly small sets, a few large ones and a few that overrun the store.
    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 1;
        if (r < 70) return $urandom_range(2, 6);
        if (r < 92) return $urandom_range(7, 20);
        if (r < 97) return $urandom_range(21, MAX_ELEMS);
        return $urandom_range(MAX_ELEMS + 1, MAX_ELEMS + 4);
    endfunction

    function automatic t_elem pick_target();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom_range(0, 20)) - 10;
            4, 5:       return $urandom();
            6:          return ELEM_MIN;
            7:          return ELEM_MAX;
            8:          return -1;
            default:    return 0;
        endcase
    endfunction

    // A random set. Planted pairs sit at random positions, so on an overrun set
    // one or both may land in the dropped tail.
    task automatic send_rand_set(input int n, input t_elem tgt);
        t_elem  vals [$];
        int     style;
        int     p1;
        int     p2;
        longint a;
        longint b;
        style = $urandom_range(0, 9);
        for (int k = 0; k < n; k++) vals.push_back(draw_value(style));
        if (n >= 2 && (style <= 3 || style == 9)) begin
            p1 = $urandom_range(0, n - 2);
            p2 = $urandom_range(p1 + 1, n - 1);
            a  = longint'(vals[p1]);
            b  = longint'(tgt) - a;
            if (b > LIM_HI || b < LIM_LO) begin
                // partner out of range: split the target in halves instead
                a = longint'(tgt) >>> 1;
                b = longint'(tgt) - a;
            end
            if (style == 9) b = (b == LIM_HI) ? b - 1 : b + 1;
            vals[p1] = a[ELEM_W-1:0];
            vals[p2] = b[ELEM_W-1:0];
        end
        send_set(vals);
    endtask

    initial begin
        t_elem vals [$];
        t_elem tgt;
        int    n_sets;

        elem_ch.valid         = 1'b0;
        elem_ch.element_value = '0;
        elem_ch.last_element  = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.target_sum     = '0;
        i_rst_n               = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sets, target still at its reset value of zero.
        vals = '{7};              send_set(vals);  // lone element: never a pair
        vals = '{0, 5};           send_set(vals);  // 0 must not pair with itself
        vals = '{9, -3, 3};       send_set(vals);  // pair only once sorted
        vals = '{0, 0};           send_set(vals);  // equal values, distinct slots
        drain(PHASE_GAP);

        // Full-width sums: a 32-bit wrap would give a false hit in both.
        write_target(-2);
        vals = '{ELEM_MAX, ELEM_MAX};            send_set(vals);
        drain(PHASE_GAP);
        write_target(0);
        vals = '{ELEM_MIN, ELEM_MIN};            send_set(vals);
        drain(PHASE_GAP);

        // Target extremes.
        write_target(ELEM_MIN);
        vals = '{5, ELEM_MIN, 0};                send_set(vals);
        drain(PHASE_GAP);
        write_target(ELEM_MAX);
        vals = '{-1, ELEM_MAX, 1, 0};            send_set(vals);
        vals = '{ELEM_MAX - 1, ELEM_MIN, 2};     send_set(vals);
        drain(PHASE_GAP);

        // Store overrun: one word past full (last word dropped), then three past.
        idle_on = 1'b1;
        tgt     = pick_target();
        write_target(tgt);
        send_rand_set(MAX_ELEMS + 1, tgt);
        send_rand_set(MAX_ELEMS + 3, tgt);
        drain(PHASE_GAP);

        // Random phases, each under its own target, some without any idling.
        while (items_sent < N_ITEMS) begin
            tgt     = pick_target();
            idle_on = ($urandom_range(0, 3) != 0);
            write_target(tgt);
            n_sets = $urandom_range(3, 10);
            repeat (n_sets) send_rand_set(pick_size(), tgt);
            drain(PHASE_GAP);
        end

        drain(END_SETTLE);
        if (chk_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
